>>> rtl/core/ssnf_pkg.sv
package ssnf_pkg;

    localparam int IN_WIDTH   = 44;
    localparam int PREC_WIDTH = 8;
    localparam int MULT_WIDTH = 24;
    localparam int NUM_WIDTH  = 31;
    localparam int ADDR_WIDTH = 4;
    localparam int CODE_WIDTH = 8;
    localparam int CNT_WIDTH  = 4;

    localparam logic [3:0] CODE_DASH  = 4'hA;
    localparam logic [3:0] CODE_BLANK = 4'hF;
    localparam logic [CODE_WIDTH-1:0] CODE_POINT = 8'd128;

    localparam logic [NUM_WIDTH-1:0] SAT_LIMIT = 31'h7FFF_FFFF;
    localparam logic [CNT_WIDTH-1:0] DEFAULT_COUNT = 4'd4;

    // ceil(2^35 / 10), exact quotient for any 32-bit dividend
    localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCD;

    typedef logic [2:0] prec_t;

    function automatic logic [MULT_WIDTH-1:0] pow10(input prec_t p);
        logic [MULT_WIDTH-1:0] r;
        case (p)
            3'd0:    r = 24'd1;
            3'd1:    r = 24'd10;
            3'd2:    r = 24'd100;
            3'd3:    r = 24'd1000;
            3'd4:    r = 24'd10000;
            3'd5:    r = 24'd100000;
            3'd6:    r = 24'd1000000;
            3'd7:    r = 24'd10000000;
            default: r = 24'd1;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/core/seven_segment_number_formatter.sv
// m_tvalid rises once an input has passed stages 1 to 3 and the digit emitter.
// The digit emitter produces one digit per cycle while m_tready does not stall it, digit_count
// digits (4..MAX_DIGITS) per number; the three front stages overlap with it.
// Reset (rst_n low, asynchronous): all stages empty, digit_count back to 4.
// The output register lets the next digit wait while m_tready is low.
module seven_segment_number_formatter #(
    parameter int MAX_DIGITS = 8,
    parameter int FRAC_BITS  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,    // [43:0] number_q16, [51:44] precision, [55:52] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [3:0] digit_address, [11:4] digit_code, [15:12] zero
    output logic        m_tlast,    // last_digit
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data    // digit_count
);

    localparam int FW = (FRAC_BITS > 0) ? FRAC_BITS : 1;
    localparam int IW = ssnf_pkg::IN_WIDTH;
    localparam int MW = ssnf_pkg::MULT_WIDTH;
    localparam int NW = ssnf_pkg::NUM_WIDTH;
    localparam int PW = NW + MW;
    localparam int SW = PW + 1;
    localparam logic [IW-1:0] FMASK = (IW'(1) << FRAC_BITS) - IW'(1);

    // configuration
    logic [ssnf_pkg::CNT_WIDTH-1:0] digit_count_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_count_reg <= ssnf_pkg::DEFAULT_COUNT;
        end
        else if (cfg_valid)
        begin
            if (cfg_data >= 4'd4 && 32'(cfg_data) <= MAX_DIGITS)
                digit_count_reg <= cfg_data;
            else
                digit_count_reg <= ssnf_pkg::DEFAULT_COUNT;
        end
    end

    // stage valids and ready chain
    logic v1_reg, v2_reg, v3_reg;
    logic r1, r2, r3;
    logic em_busy_reg;
    logic out_load;
    logic em_step;
    logic em_last;

    assign out_load = !m_tvalid || m_tready;
    assign em_step  = em_busy_reg && out_load;
    assign r3       = !em_busy_reg || (em_step && em_last);
    assign r2       = !v3_reg || r3;
    assign r1       = !v2_reg || r2;
    assign s_tready = !v1_reg || r1;

    // stage 1: input register
    logic [IW-1:0] raw1_reg;
    logic [ssnf_pkg::PREC_WIDTH-1:0] prec1_reg;

    // stage 2: magnitude split
    logic [NW-1:0] ipart2_reg;
    logic [FW-1:0] fpart2_reg;
    logic [MW-1:0] mult2_reg;
    logic          sat2_reg;
    logic          neg2_reg;
    ssnf_pkg::prec_t prec2_reg;

    logic [IW-1:0] mag;
    logic [IW-1:0] ipart;
    logic          neg1;
    ssnf_pkg::prec_t prec_adj;

    always_comb
    begin
        neg1  = raw1_reg[IW-1];
        mag   = neg1 ? (IW'(0) - raw1_reg) : raw1_reg;
        ipart = mag >> FRAC_BITS;
        if (neg1)
            prec_adj = (prec1_reg > 8'd6) ? 3'd6 : prec1_reg[2:0];
        else
            prec_adj = (prec1_reg > 8'd7) ? 3'd0 : prec1_reg[2:0];
    end

    // stage 3: products
    logic [PW-1:0]    pi3_reg;
    logic [FW+MW-1:0] pf3_reg;
    logic             sat3_reg;
    logic             neg3_reg;
    ssnf_pkg::prec_t  prec3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                v1_reg <= s_tvalid;
            if (r1)
                v2_reg <= v1_reg;
            if (r2)
                v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            raw1_reg  <= s_tdata[IW-1:0];
            prec1_reg <= s_tdata[IW+ssnf_pkg::PREC_WIDTH-1:IW];
        end
        if (r1 && v1_reg)
        begin
            ipart2_reg <= ipart[NW-1:0];
            fpart2_reg <= FW'(mag & FMASK);
            mult2_reg  <= ssnf_pkg::pow10(prec_adj);
            sat2_reg   <= (ipart > IW'(ssnf_pkg::SAT_LIMIT));
            neg2_reg   <= neg1;
            prec2_reg  <= prec_adj;
        end
        if (r2 && v2_reg)
        begin
            pi3_reg   <= PW'(ipart2_reg) * PW'(mult2_reg);
            pf3_reg   <= (FW + MW)'(fpart2_reg) * (FW + MW)'(mult2_reg);
            sat3_reg  <= sat2_reg;
            neg3_reg  <= neg2_reg;
            prec3_reg <= prec2_reg;
        end
    end

    // digit emitter
    logic [NW-1:0] sum_num;
    logic [SW-1:0] sum;
    logic          em_load;

    assign em_load = r3 && v3_reg;

    always_comb
    begin
        sum = SW'(pi3_reg) + SW'(pf3_reg >> FRAC_BITS);
        if (sat3_reg || sum > SW'(ssnf_pkg::SAT_LIMIT))
            sum_num = ssnf_pkg::SAT_LIMIT;
        else
            sum_num = sum[NW-1:0];
    end

    logic [NW-1:0]                  num_reg, num_next;
    logic [ssnf_pkg::ADDR_WIDTH-1:0] d_reg, d_next;
    logic                           neg_reg;
    ssnf_pkg::prec_t                prec_reg;
    logic                           dash_done_reg, dash_done_next;
    logic                           em_busy_next;

    logic [63:0]                     prod;
    logic [NW-1:0]                   quot;
    logic [NW-1:0]                   quot10;
    logic [3:0]                      rem;
    logic [ssnf_pkg::ADDR_WIDTH-1:0] point_pos;
    logic [ssnf_pkg::CODE_WIDTH-1:0] code;
    logic                            blank;

    always_comb
    begin
        prod      = 64'(num_reg) * 64'(ssnf_pkg::DIV10_RECIP);
        quot      = NW'(prod[63:35]);
        quot10    = (quot << 3) + (quot << 1);
        rem       = 4'(num_reg - quot10);
        point_pos = {1'b0, prec_reg} + 4'd1;
        blank     = (num_reg == '0) && (d_reg > point_pos);
        em_last   = (d_reg == digit_count_reg);
        dash_done_next = dash_done_reg;
        code      = {4'd0, rem};
        if (blank)
        begin
            if (neg_reg && !dash_done_reg)
            begin
                code = {4'd0, ssnf_pkg::CODE_DASH};
                dash_done_next = 1'b1;
            end
            else
            begin
                code = {4'd0, ssnf_pkg::CODE_BLANK};
            end
        end
        if (d_reg == point_pos && prec_reg != 3'd0)
            code = code | ssnf_pkg::CODE_POINT;
    end

    always_comb
    begin
        em_busy_next = em_busy_reg;
        num_next     = num_reg;
        d_next       = d_reg;
        if (em_step)
        begin
            num_next = quot;
            d_next   = d_reg + 4'd1;
            if (em_last)
                em_busy_next = 1'b0;
        end
        if (em_load)
        begin
            em_busy_next   = 1'b1;
            num_next       = sum_num;
            d_next         = 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            em_busy_reg <= 1'b0;
            m_tvalid    <= 1'b0;
        end
        else
        begin
            em_busy_reg <= em_busy_next;
            if (out_load)
                m_tvalid <= em_busy_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        d_reg   <= d_next;
        if (em_load)
        begin
            neg_reg       <= neg3_reg;
            prec_reg      <= prec3_reg;
            dash_done_reg <= 1'b0;
        end
        else if (em_step)
        begin
            dash_done_reg <= dash_done_next;
        end
        if (em_step)
        begin
            m_tdata <= {4'd0, code, d_reg};
            m_tlast <= em_last;
        end
    end

endmodule

>>> rtl/core/ssnf_checker.sv
module ssnf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast
);

    // stalled transaction holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output changed while stalled");

    // digit address stays within 1..8
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[3:0] != 4'd0 && m_tdata[3:0] <= 4'd8)
        else $error("digit address out of range");

    // at least four digits per number
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tdata[3:0] >= 4'd4)
        else $error("number ended before fourth digit");

    // code nibble is a BCD digit, dash or blank; only the point bit above it
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[7:4] <= 4'd9 || m_tdata[7:4] == ssnf_pkg::CODE_DASH
                      || m_tdata[7:4] == ssnf_pkg::CODE_BLANK) && m_tdata[10:8] == 3'd0
                      && m_tdata[15:12] == 4'd0)
        else $error("bad digit code");

endmodule

bind seven_segment_number_formatter ssnf_checker u_ssnf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

>>> tb/seven_segment_number_formatter_test.sv
module seven_segment_number_formatter_test;

    localparam int MAX_DIGITS  = 8;
    localparam int FRAC_BITS   = 16;
    localparam int IDLE_PCT    = 27;
    localparam int CYCLE_LIMIT = 200000;
    localparam int IN_WIDTH    = ssnf_pkg::IN_WIDTH;
    localparam int PREC_WIDTH  = ssnf_pkg::PREC_WIDTH;
    localparam int ADDR_WIDTH  = ssnf_pkg::ADDR_WIDTH;
    localparam int CODE_WIDTH  = ssnf_pkg::CODE_WIDTH;

    typedef struct packed {
        logic [ADDR_WIDTH-1:0] addr;
        logic [CODE_WIDTH-1:0] code;
        logic                  last;
    } digit_write_t;

    class digit_tracker;
        digit_write_t expected_digits[$];
        int unsigned  errors;
        int unsigned  checked;

        function int unsigned pending_count();
            return expected_digits.size();
        endfunction

        // works out the digit writes for one accepted number
        function void note_number(logic [IN_WIDTH-1:0] raw, logic [PREC_WIDTH-1:0] prec_in,
                                  int unsigned count);
            logic                  neg;
            logic [IN_WIDTH-1:0]   mag;
            logic [PREC_WIDTH-1:0] prec;
            logic [63:0]           mult;
            logic [63:0]           scaled;
            logic [63:0]           whole;
            logic [63:0]           frac;
            logic [CODE_WIDTH-1:0] code;
            int unsigned           point_pos;
            bit                    dash_done;
            digit_write_t          w;
            neg  = raw[IN_WIDTH-1];
            mag  = neg ? (~raw + 1'b1) : raw;
            prec = prec_in;
            if (neg && prec > 6)
                prec = 6;
            else if (!neg && prec > 7)
                prec = 0;
            mult = 64'd1;
            repeat (prec) mult = mult * 10;
            whole = 64'(mag >> FRAC_BITS);
            frac  = 64'(mag[FRAC_BITS-1:0]);
            if (whole > 64'(ssnf_pkg::SAT_LIMIT))
            begin
                scaled = 64'(ssnf_pkg::SAT_LIMIT);
            end
            else
            begin
                scaled = whole * mult + ((frac * mult) >> FRAC_BITS);
                if (scaled > 64'(ssnf_pkg::SAT_LIMIT))
                    scaled = 64'(ssnf_pkg::SAT_LIMIT);
            end
            point_pos = prec + 1;
            dash_done = 0;
            for (int unsigned d = 1; d <= count; d++)
            begin
                code = CODE_WIDTH'(scaled % 10);
                if (scaled == 0 && d > point_pos)
                begin
                    if (neg && !dash_done)
                    begin
                        code      = {4'h0, ssnf_pkg::CODE_DASH};
                        dash_done = 1;
                    end
                    else
                    begin
                        code = {4'h0, ssnf_pkg::CODE_BLANK};
                    end
                end
                scaled = scaled / 10;
                if (d == point_pos && prec != 0)
                    code = code | ssnf_pkg::CODE_POINT;
                w.addr = ADDR_WIDTH'(d);
                w.code = code;
                w.last = (d == count);
                expected_digits.push_back(w);
            end
        endfunction

        function void check_digit(logic [ADDR_WIDTH-1:0] addr, logic [CODE_WIDTH-1:0] code,
                                  logic last);
            digit_write_t w;
            if (expected_digits.size() == 0)
            begin
                $error("unexpected digit transaction: address %0d code 0x%0h last %0b",
                       addr, code, last);
                errors++;
                return;
            end
            w = expected_digits.pop_front();
            checked++;
            if (w.addr !== addr)
            begin
                $error("digit_address: expected %0d, actual %0d", w.addr, addr);
                errors++;
            end
            if (w.code !== code)
            begin
                $error("digit_code: expected 0x%0h, actual 0x%0h", w.code, code);
                errors++;
            end
            if (w.last !== last)
            begin
                $error("last_digit: expected %0b, actual %0b", w.last, last);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;    // [43:0] number_q16, [51:44] precision, [55:52] zero
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;    // [3:0] digit_address, [11:4] digit_code, [15:12] zero
    logic        m_tlast;    // last_digit
    logic        cfg_valid;
    logic        cfg_ready;
    logic [3:0]  cfg_data;   // digit_count

    digit_tracker tracker;
    int unsigned  digit_count;
    int unsigned  numbers_sent;
    int unsigned  settings_used;
    int unsigned  cycles;
    bit           calm;

    seven_segment_number_formatter #(
        .MAX_DIGITS(MAX_DIGITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge clk)
        m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            tracker.check_digit(m_tdata[3:0], m_tdata[11:4], m_tlast);

    task automatic send_number(input logic [IN_WIDTH-1:0] number,
                               input logic [PREC_WIDTH-1:0] prec);
        if (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'h0, prec, number};
        do @(posedge clk); while (!s_tready);
        tracker.note_number(number, prec, digit_count);
        numbers_sent++;
    endtask

    // let every expected digit arrive, plus some slack, before touching the register
    task automatic drain_digits();
        s_tvalid <= 1'b0;
        while (tracker.pending_count() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_digit_count(input logic [3:0] value);
        drain_digits();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        digit_count = (value >= 4 && value <= MAX_DIGITS) ? value : ssnf_pkg::DEFAULT_COUNT;
        settings_used++;
    endtask

    function automatic logic [IN_WIDTH-1:0] random_number();
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(3))
            0:       return r[IN_WIDTH-1:0];
            1:       return IN_WIDTH'($signed(r[23:0]));
            2:       return IN_WIDTH'($signed(r[31:0]));
            default: return IN_WIDTH'($signed(r[16:0]));
        endcase
    endfunction

    function automatic logic [PREC_WIDTH-1:0] random_precision();
        if ($urandom_range(4) == 0)
            return PREC_WIDTH'($urandom);
        return PREC_WIDTH'($urandom_range(9));
    endfunction

    initial
    begin
        logic [3:0] phase_counts[10];
        clk           = 1'b0;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        m_tready      = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        calm          = 0;
        cycles        = 0;
        numbers_sent  = 0;
        settings_used = 1;
        digit_count   = ssnf_pkg::DEFAULT_COUNT;
        tracker       = new();
        phase_counts  = '{4'd5, 4'd0, 4'd8, 4'd15, 4'd6, 4'd9, 4'd7, 4'd3, 4'd8, 4'd4};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // four digits from reset
        send_number(44'd0, 8'd0);
        send_number(44'h0_0001_8000, 8'd1);
        send_number(-44'sd212992, 8'd2);
        send_number(44'h7FF_FFFF_FFFF, 8'd0);
        send_number(44'h7FF_FFFF_FFFF, 8'd7);
        send_number(44'h800_0000_0000, 8'd6);
        send_number(44'h800_0000_0000, 8'd255);
        send_number(-44'sd1, 8'd0);
        send_number(-44'sd1, 8'd6);
        send_number(-44'sd80871424, 8'd0);        // -1234: no blank left for the dash
        send_number(44'd809041, 8'd5);            // point pushed off the display
        send_number(44'h0_0003_0000, 8'd8);
        send_number(44'h0_0003_0000, 8'd255);
        send_number(44'h0_00FF_FFFF, 8'd3);
        send_number(44'd327680000, 8'd7);         // 5000 * 10^7 saturates
        send_number(44'h0_0002_8000, 8'd7);

        write_digit_count(4'd8);
        send_number(44'h7FF_FFFF_FFFF, 8'd0);
        send_number(44'h800_0000_0000, 8'd0);
        send_number(-44'sd32768, 8'd3);
        send_number(44'h0_0007_4000, 8'd7);
        send_number(-44'sd475136, 8'd7);
        send_number(44'h555_5555_5555, 8'd4);
        send_number(44'hAAA_AAAA_AAAA, 8'd170);

        for (int p = 0; p < 10; p++)
        begin
            write_digit_count(phase_counts[p]);
            calm = (p == 4);
            for (int i = 0; i < 25; i++)
                send_number(random_number(), random_precision());
            calm = 0;
        end

        drain_digits();
        $display("%0d numbers over %0d digit-count settings (invalid writes included),",
                 numbers_sent, settings_used);
        $display("%0d digit transactions checked, %0d mismatches", tracker.checked,
                 tracker.errors);
        if (tracker.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

>>> seven_segment_number_formatter.f
rtl/core/ssnf_pkg.sv
rtl/core/seven_segment_number_formatter.sv
rtl/core/ssnf_checker.sv
tb/seven_segment_number_formatter_test.sv
